// File: rtl/core/rnbt_pkg.sv
package rnbt_pkg;

	localparam int NUM_SLOTS  = 16;
	localparam int KEY_BITS   = 64;
	localparam int COUNT_BITS = 16;

	localparam int SLOT_BITS  = $clog2(NUM_SLOTS);
	localparam int OCC_BITS   = $clog2(NUM_SLOTS + 1);

	localparam int IN_KEY_BITS     = 64;
	localparam int OUT_STATUS_BITS = 3;
	localparam int OUT_HANDLE_BITS = 4;
	localparam int OUT_COUNT_BITS  = 16;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [OUT_STATUS_BITS-1:0] {
		ST_FOUND      = 3'd0,
		ST_CREATED    = 3'd1,
		ST_FULL       = 3'd2,
		ST_STILL_USED = 3'd3,
		ST_FREED      = 3'd4,
		ST_FAIL       = 3'd5
	} rnbt_status_t;

	typedef enum logic {
		ACT_ACQUIRE = 1'b0,
		ACT_RELEASE = 1'b1
	} rnbt_action_t;

	typedef struct packed {
		logic load;
		logic inc_idx;
		logic update;
		logic move;
	} rnbt_cmd_t;

	typedef struct packed {
		logic at_end;
		logic match;
		logic need_move;
	} rnbt_stat_t;

endpackage

// File: rtl/core/rnbt_datapath.sv
module rnbt_datapath import rnbt_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rnbt_cmd_t                  cmd,
	input  logic                       action,
	input  logic [IN_KEY_BITS-1:0]     name_key,
	output rnbt_stat_t                 stat,
	output logic [OUT_STATUS_BITS-1:0] status,
	output logic [OUT_HANDLE_BITS-1:0] buffer_handle,
	output logic [OUT_COUNT_BITS-1:0]  user_count
);

	logic                  action_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [OCC_BITS-1:0]   idx_q;
	logic [OCC_BITS-1:0]   occ_q;
	logic [NUM_SLOTS-1:0]  free_q;

	logic [KEY_BITS-1:0]   slot_key_q    [NUM_SLOTS];
	logic [COUNT_BITS-1:0] slot_count_q  [NUM_SLOTS];
	logic [SLOT_BITS-1:0]  slot_handle_q [NUM_SLOTS];

	rnbt_status_t          res_status_q;
	logic [SLOT_BITS-1:0]  res_handle_q;
	logic [COUNT_BITS-1:0] res_count_q;

	logic [SLOT_BITS-1:0]  rd_addr;
	logic [KEY_BITS-1:0]   rd_key;
	logic [COUNT_BITS-1:0] rd_count;
	logic [SLOT_BITS-1:0]  rd_handle;
	logic                  hit;
	logic [SLOT_BITS-1:0]  new_handle;

	logic                  wr_en;
	logic [SLOT_BITS-1:0]  wr_addr;
	logic [KEY_BITS-1:0]   wr_key;
	logic [COUNT_BITS-1:0] wr_count;
	logic [SLOT_BITS-1:0]  wr_handle;
	logic                  alloc;
	logic                  drop;
	rnbt_status_t          res_status;
	logic [SLOT_BITS-1:0]  res_handle;
	logic [COUNT_BITS-1:0] res_count;

	assign rd_addr   = cmd.move ? occ_q[SLOT_BITS-1:0] : idx_q[SLOT_BITS-1:0];
	assign rd_key    = slot_key_q[rd_addr];
	assign rd_count  = slot_count_q[rd_addr];
	assign rd_handle = slot_handle_q[rd_addr];
	assign hit       = idx_q < occ_q;

	assign stat.at_end    = !hit;
	assign stat.match     = rd_key == key_q;
	assign stat.need_move = (action_q == ACT_RELEASE) && hit &&
		(rd_count <= COUNT_BITS'(1));

	// lowest free handle
	always_comb begin
		new_handle = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				new_handle = SLOT_BITS'(i);
			end
		end
	end

	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = idx_q[SLOT_BITS-1:0];
		wr_key     = rd_key;
		wr_count   = rd_count;
		wr_handle  = rd_handle;
		alloc      = 1'b0;
		drop       = 1'b0;
		res_status = ST_FAIL;
		res_handle = '0;
		res_count  = '0;
		if (action_q == ACT_ACQUIRE) begin
			if (hit) begin
				if (rd_count == COUNT_MAX) begin
					res_count = rd_count;
				end else begin
					wr_en      = 1'b1;
					wr_count   = rd_count + COUNT_BITS'(1);
					res_status = ST_FOUND;
					res_handle = rd_handle;
					res_count  = rd_count + COUNT_BITS'(1);
				end
			end else if (occ_q == OCC_BITS'(NUM_SLOTS)) begin
				res_status = ST_FULL;
			end else begin
				wr_en      = 1'b1;
				wr_addr    = occ_q[SLOT_BITS-1:0];
				wr_key     = key_q;
				wr_count   = COUNT_BITS'(1);
				wr_handle  = new_handle;
				alloc      = 1'b1;
				res_status = ST_CREATED;
				res_handle = new_handle;
				res_count  = COUNT_BITS'(1);
			end
		end else if (hit) begin
			if (rd_count > COUNT_BITS'(1)) begin
				wr_en      = 1'b1;
				wr_count   = rd_count - COUNT_BITS'(1);
				res_status = ST_STILL_USED;
				res_handle = rd_handle;
				res_count  = rd_count - COUNT_BITS'(1);
			end else begin
				drop       = 1'b1;
				res_status = ST_FREED;
				res_handle = rd_handle;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			occ_q  <= '0;
			free_q <= '1;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.inc_idx) begin
				idx_q <= idx_q + OCC_BITS'(1);
			end
			if (cmd.update && alloc) begin
				occ_q            <= occ_q + OCC_BITS'(1);
				free_q[new_handle] <= 1'b0;
			end
			if (cmd.update && drop) begin
				occ_q             <= occ_q - OCC_BITS'(1);
				free_q[rd_handle] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			key_q    <= name_key[KEY_BITS-1:0];
		end
		if (cmd.update) begin
			res_status_q <= res_status;
			res_handle_q <= res_handle;
			res_count_q  <= res_count;
			if (wr_en) begin
				slot_key_q[wr_addr]    <= wr_key;
				slot_count_q[wr_addr]  <= wr_count;
				slot_handle_q[wr_addr] <= wr_handle;
			end
		end
		// last slot fills the hole
		if (cmd.move) begin
			slot_key_q[idx_q[SLOT_BITS-1:0]]    <= rd_key;
			slot_count_q[idx_q[SLOT_BITS-1:0]]  <= rd_count;
			slot_handle_q[idx_q[SLOT_BITS-1:0]] <= rd_handle;
		end
	end

	assign status        = res_status_q;
	assign buffer_handle = OUT_HANDLE_BITS'(res_handle_q);
	assign user_count    = OUT_COUNT_BITS'(res_count_q);

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_BITS'(NUM_SLOTS))
		else $error("occupancy beyond table size");

	a_handle_balance: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(free_q) + int'(occ_q)) == NUM_SLOTS)
		else $error("free handles and occupied slots out of balance");

	a_move_after_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move |-> $past(cmd.update) && $past(drop))
		else $error("slot move without a freed entry");

endmodule

// File: rtl/core/rnbt_ctrl.sv
module rnbt_ctrl import rnbt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  rnbt_stat_t stat,
	output rnbt_cmd_t  cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE,
		S_MOVE
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	assign cmd.load    = (state_q == S_IDLE) && start;
	assign cmd.inc_idx = (state_q == S_SCAN) && !stat.at_end && !stat.match;
	assign cmd.update  = state_q == S_UPDATE;
	assign cmd.move    = state_q == S_MOVE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						busy_q  <= 1'b1;
					end
				end
				S_SCAN: begin
					if (stat.at_end || stat.match) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (stat.need_move) begin
						state_q <= S_MOVE;
					end else begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
					end
				end
				S_MOVE: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != S_IDLE))
		else $error("busy disagrees with state");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy_q) |=> busy_q && !done_q)
		else $error("accepted beat did not raise busy");

	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_UPDATE) || $past(state_q == S_MOVE))
		else $error("result strobe outside update");

endmodule

// File: rtl/core/refcounted_named_buffer_table_core.sv
// Reference-counted table of named buffers.
// Request channel: drive action and name_key with start high; the beat is
// taken at a rising edge where start is high and busy is low. busy stays
// high until the result has been produced.
// Result channel: done is high for exactly one cycle with status,
// buffer_handle and user_count valid; the receiver cannot stall it, and the
// values hold until the next result.
// Sequence: from accept, the controller scans the occupied slots in order
// (S_SCAN) until a key match or the end of the occupied range, then writes
// the result in S_UPDATE; a release that frees an entry adds S_MOVE, where
// the last slot is copied into the hole. The scan reads one slot per cycle
// through a single read mux.
// A new request may be started in the cycle done is high.
// Reset (arst_n low) empties the table and frees every handle; slot
// contents are not cleared, as only occupied slots are ever read.
module refcounted_named_buffer_table_core import rnbt_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       action,
	input  logic [IN_KEY_BITS-1:0]     name_key,
	output logic                       done,
	output logic [OUT_STATUS_BITS-1:0] status,
	output logic [OUT_HANDLE_BITS-1:0] buffer_handle,
	output logic [OUT_COUNT_BITS-1:0]  user_count
);

	rnbt_cmd_t  cmd;
	rnbt_stat_t stat;

	rnbt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	rnbt_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.action        (action),
		.name_key      (name_key),
		.stat          (stat),
		.status        (status),
		.buffer_handle (buffer_handle),
		.user_count    (user_count)
	);

endmodule
